### rtl/urcd_pkg.sv
// Package for the UDP receive checker and port demultiplexer.
// Holds request kinds, packet status codes and the ones' complement adder.
package urcd_pkg;

  localparam int TableEntriesDefault = 16;

  typedef enum logic [1:0] {
    KIND_BIND   = 2'd0,
    KIND_UNBIND = 2'd1,
    KIND_BYTE   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_SUM   = 3'd3,
    ST_UNBOUND   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SUM,
    PH_LOOKUP,
    PH_DONE
  } phase_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

### rtl/urcd_table.sv
// Port binding table: valid bits in flip-flops, ports and handles in a memory.
// Depends on urcd_pkg.
module urcd_table import urcd_pkg::*; #(
  parameter int TableEntries = TableEntriesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        lookup,
  input  logic [15:0] lookup_port,
  input  logic        bind_req,
  input  logic        unbind_req,
  input  logic [7:0]  handle,
  output logic        found,
  output logic        bind_ok,
  output logic        unbind_ok,
  output logic [7:0]  found_receiver
);
  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  logic [15:0] port_mem [TableEntries];
  logic [7:0]  recv_mem [TableEntries];
  logic [TableEntries-1:0] valid;
  logic [TableEntries-1:0] hit;
  logic [IdxW-1:0] hit_idx;
  logic [IdxW-1:0] free_idx;
  logic any_hit;
  logic any_free;
  logic [IdxW-1:0] rd_idx;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    any_hit  = 1'b0;
    any_free = 1'b0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      hit[i] = valid[i] && (port_mem[i] == lookup_port);
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid[i]) begin
        any_free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign bind_ok   = bind_req && !any_hit && any_free;
  assign unbind_ok = unbind_req && any_hit;

  always_ff @(posedge clk) begin
    if (bind_ok) begin
      port_mem[free_idx] <= lookup_port;
      recv_mem[free_idx] <= handle;
    end
    if (lookup) begin
      rd_idx <= hit_idx;
      found  <= any_hit;
    end
  end

  assign found_receiver = recv_mem[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (bind_ok) begin
      valid[free_idx] <= 1'b1;
    end else if (unbind_ok) begin
      valid[hit_idx] <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(bind_ok && unbind_ok))
    else $error("bind and unbind together");
  assert property (@(posedge clk) disable iff (rst) $onehot0(hit))
    else $error("port bound twice");
  assert property (@(posedge clk) disable iff (rst) bind_ok |=> valid != '0)
    else $error("bind left no valid entry");
endmodule

### rtl/udp_receive_check_and_port_demux_unit.sv
// UDP receive checker with port binding table.
//
// One input channel (in_valid / in_stall) carries bind, unbind and packet byte
// requests; one output channel (out_valid / out_stall) carries a verdict for
// each bind, unbind and last packet byte. Kind three is dropped silently.
// Bind and unbind answer in the cycle after acceptance. Packet bytes are taken
// one per cycle while idle; on the last byte the block adds the padded odd
// byte and the six pseudo-header words, one adder step per cycle, then reads
// the table memory; the verdict is registered from the done phase. The next
// request is held by in_stall until the block is idle again. A new request is
// taken while a result waits only when it causes no result; otherwise in_stall
// holds it. While out_valid and out_stall are both high the result register
// holds its value. Reset clears the binding valid bits, the packet state and
// out_valid; nothing else. Depends on urcd_pkg and urcd_table.
module udp_receive_check_and_port_demux_unit import urcd_pkg::*; #(
  parameter int TableEntries = TableEntriesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] port,
  input  logic [7:0]  receiver_handle,
  input  logic [31:0] source_ip,
  input  logic [31:0] dest_ip,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind_echo,
  output logic        success,
  output logic [2:0]  packet_status,
  output logic [7:0]  receiver,
  output logic [15:0] source_port,
  output logic [15:0] payload_length
);
  phase_t phase, phase_next;
  logic [15:0] byte_count;
  logic [15:0] running_sum;
  logic [7:0]  odd_byte_hold;
  logic [63:0] header_fields;
  logic [15:0] sum_word [7];
  logic [2:0]  step;
  logic [15:0] sum;
  logic [15:0] ulen;
  logic [2:0]  verdict;
  logic        use_sum;
  logic        accept;
  logic        out_free;
  logic        table_bind;
  logic        table_unbind;
  logic        table_lookup;
  logic [15:0] table_port;
  logic        found;
  logic        bind_ok;
  logic        unbind_ok;
  logic [7:0]  found_receiver;
  logic        counted;
  logic [15:0] nb;
  logic [15:0] final_sum;
  logic [15:0] cnt_final;
  logic [15:0] hdr_len;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (phase != PH_IDLE) ||
                    (!out_free && (kind == KIND_BIND || kind == KIND_UNBIND ||
                                   (kind == KIND_BYTE && last_byte)));
  assign accept = in_valid && !in_stall;

  assign table_bind   = accept && kind == KIND_BIND;
  assign table_unbind = accept && kind == KIND_UNBIND;
  assign table_lookup = phase == PH_LOOKUP;
  assign table_port   = table_lookup ? header_fields[47:32] : port;

  urcd_table #(.TableEntries(TableEntries)) u_table (
    .clk(clk), .rst(rst),
    .lookup(table_lookup), .lookup_port(table_port),
    .bind_req(table_bind), .unbind_req(table_unbind),
    .handle(receiver_handle),
    .found(found), .bind_ok(bind_ok), .unbind_ok(unbind_ok),
    .found_receiver(found_receiver)
  );

  assign hdr_len = header_fields[31:16];
  assign counted = (byte_count < 16'd8) || (byte_count < hdr_len);
  assign nb = (byte_count == 16'hFFFF) ? byte_count : byte_count + 16'd1;
  assign ulen = header_fields[31:16];
  assign use_sum = header_fields[15:0] != 16'd0;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:   if (accept && kind == KIND_BYTE && last_byte) phase_next = PH_SUM;
      PH_SUM:    if (step == 3'd6) phase_next = PH_LOOKUP;
      PH_LOOKUP: phase_next = PH_DONE;
      PH_DONE:   if (out_free) phase_next = PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Per-byte header and sum state (computed combinationally for the capture).
  logic [63:0] hdr_now;
  logic [15:0] sum_now;
  logic [7:0]  hold_now;
  always_comb begin
    hdr_now  = header_fields;
    sum_now  = running_sum;
    hold_now = odd_byte_hold;
    if (byte_count < 16'd8) hdr_now = {header_fields[55:0], data_byte};
    if (counted) begin
      if (!byte_count[0]) hold_now = data_byte;
      else sum_now = oc_add(running_sum, {odd_byte_hold, data_byte});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      running_sum   <= '0;
      odd_byte_hold <= '0;
      header_fields <= '0;
      step          <= '0;
    end else if (accept && kind == KIND_BYTE) begin
      header_fields <= hdr_now;
      running_sum   <= sum_now;
      odd_byte_hold <= hold_now;
      byte_count    <= nb;
      if (last_byte) begin
        step <= '0;
        sum  <= sum_now;
        cnt_final <= nb;
        sum_word[0] <= hdr_now[16] ? {hold_now, 8'd0} : 16'd0;
        sum_word[1] <= source_ip[31:16];
        sum_word[2] <= source_ip[15:0];
        sum_word[3] <= dest_ip[31:16];
        sum_word[4] <= dest_ip[15:0];
        sum_word[5] <= 16'd17;
        sum_word[6] <= hdr_now[31:16];
      end
    end else if (phase == PH_SUM) begin
      sum  <= oc_add(sum, sum_word[step]);
      step <= step + 3'd1;
    end else if (phase == PH_DONE && out_free) begin
      byte_count    <= '0;
      running_sum   <= '0;
      odd_byte_hold <= '0;
      header_fields <= '0;
    end
  end

  assign final_sum = sum;

  always_comb begin
    if (cnt_final < 16'd8) verdict = ST_SHORT;
    else if (ulen < 16'd8 || ulen > cnt_final) verdict = ST_BAD_LEN;
    else if (use_sum && final_sum != 16'hFFFF) verdict = ST_BAD_SUM;
    else if (!found) verdict = ST_UNBOUND;
    else verdict = ST_DELIVERED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= table_bind || table_unbind || phase == PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (phase == PH_DONE) begin
        kind_echo      <= KIND_BYTE;
        success        <= verdict == ST_DELIVERED;
        packet_status  <= verdict;
        receiver       <= (verdict == ST_DELIVERED) ? found_receiver : 8'd0;
        source_port    <= (verdict == ST_DELIVERED) ? header_fields[63:48] : 16'd0;
        payload_length <= (verdict == ST_DELIVERED) ? ulen - 16'd8 : 16'd0;
      end else begin
        kind_echo      <= kind;
        success        <= table_bind ? bind_ok : unbind_ok;
        packet_status  <= ST_DELIVERED;
        receiver       <= '0;
        source_port    <= '0;
        payload_length <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) phase != PH_IDLE |-> in_stall)
    else $error("request taken during verdict");
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && out_free) |=> out_valid)
    else $error("verdict lost");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(packet_status))
    else $error("stalled result changed");
endmodule
